[hw/rtl/snc_pkg.sv]
// Shared types, codes and helpers for the SPI NVRAM command sequencer.
`timescale 1ns / 1ps

package snc_pkg;

    typedef enum logic [2:0] {
        OPC_READ   = 3'd0,
        OPC_WRITE  = 3'd1,
        OPC_STATUS = 3'd2,
        OPC_ID     = 3'd3,
        OPC_SLEEP  = 3'd4,
        OPC_WAKE   = 3'd5,
        OPC_REPLY  = 3'd6,
        OPC_TICK   = 3'd7
    } t_op;

    typedef enum logic [1:0] {
        KIND_XFER = 2'd0,
        KIND_WAIT = 2'd1,
        KIND_DONE = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_RANGE       = 2'd1,
        ST_WEL_TIMEOUT = 2'd2,
        ST_WIP_TIMEOUT = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_WEL_REPLY = 3'd1,
        PH_WEL_TICK  = 3'd2,
        PH_WIP_REPLY = 3'd3,
        PH_WIP_TICK  = 3'd4
    } t_phase;

    localparam logic [7:0] SPI_READ_ID       = 8'h9F;
    localparam logic [7:0] SPI_READ_DATA     = 8'h03;
    localparam logic [7:0] SPI_WRITE_ENABLE  = 8'h06;
    localparam logic [7:0] SPI_WRITE_DISABLE = 8'h04;
    localparam logic [7:0] SPI_PAGE_PROGRAM  = 8'h0A;
    localparam logic [7:0] SPI_READ_STATUS   = 8'h05;
    localparam logic [7:0] SPI_POWER_DOWN    = 8'hB9;
    localparam logic [7:0] SPI_POWER_UP      = 8'hAB;

    localparam logic [15:0] POLL_LIMIT_RESET = 16'd1000;

    localparam int MAX_RESULTS = 3;
    localparam int QDEPTH      = 4;
    localparam int QAW         = 2;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  command;
        logic        has_address;
        logic [23:0] address_out;
        logic [8:0]  data_length;
        logic        data_in;
        t_status     status_code;
        logic        last;
    } t_result;

    typedef struct packed {
        logic                          busy;
        logic [1:0]                    count;
        t_result [MAX_RESULTS-1:0]     item;
    } t_batch;

    function automatic t_result mk_xfer(logic [7:0] cmd, logic has_addr, logic [23:0] addr,
                                        logic [8:0] dlen, logic din);
        t_result r;
        r             = '0;
        r.kind        = KIND_XFER;
        r.command     = cmd;
        r.has_address = has_addr;
        r.address_out = has_addr ? addr : 24'd0;
        r.data_length = dlen;
        r.data_in     = (dlen != 9'd0) ? din : 1'b0;
        r.status_code = ST_OK;
        return r;
    endfunction

    function automatic t_result mk_done(t_status code);
        t_result r;
        r             = '0;
        r.kind        = KIND_DONE;
        r.status_code = code;
        return r;
    endfunction

    function automatic t_result mk_wait();
        t_result r;
        r             = '0;
        r.kind        = KIND_WAIT;
        r.status_code = ST_OK;
        return r;
    endfunction

endpackage

[hw/rtl/spi_nvram_command_sequencer.sv]
// An accepted beat is captured in the input register and, once the four-entry result
// queue has room, sequenced into it; its first result beat is then valid on m_axis.
// Throughput: one input beat per cycle while the queue has room, i.e. holds at most one
// entry after this cycle's output pop; otherwise the beat waits in the input register.
// Reset (i_rst_n low, synchronous): phase idle, counters and queue cleared,
// poll_limit back to 1000.
`timescale 1ns / 1ps

module spi_nvram_command_sequencer
    import snc_pkg::*;
#(
    parameter int PAGE_BYTES   = 256,
    parameter int ADDRESS_BITS = 24
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,  // address[31:0], length[56:32], status_byte[64:57]
    input  logic [2:0]  s_axis_tuser,  // operation[2:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // command[7:0], has_address[8], address_out[32:9], data_length[41:33],
    // data_in[42], status_code[44:43]
    output logic [47:0] m_axis_tdata,
    output logic [1:0]  m_axis_tuser,  // kind[1:0]
    output logic        m_axis_tlast
);

    logic [15:0]   r_poll_limit;
    logic          r_in_valid;
    logic [2:0]    r_op;
    logic [31:0]   r_addr;
    logic [24:0]   r_len;
    logic [7:0]    r_status;

    t_result       r_q [QDEPTH];
    logic [QAW-1:0] r_wr_ptr, r_rd_ptr;
    logic [QAW:0]  r_count, n_count, cnt_after;

    logic          pop;
    logic          fire;
    t_batch        batch;
    t_result       head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_poll_limit <= POLL_LIMIT_RESET;
        end else if (i_cfg_wr_en) begin
            r_poll_limit <= i_cfg_wr_data;
        end
    end

    assign pop       = m_axis_tvalid && m_axis_tready;
    assign cnt_after = r_count - (QAW + 1)'(pop);
    assign fire      = r_in_valid && (cnt_after <= (QAW + 1)'(QDEPTH - MAX_RESULTS));
    assign s_axis_tready = !r_in_valid || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_op     <= s_axis_tuser;
            r_addr   <= s_axis_tdata[31:0];
            r_len    <= s_axis_tdata[56:32];
            r_status <= s_axis_tdata[64:57];
        end
    end

    snc_engine #(
        .PAGE_BYTES   (PAGE_BYTES),
        .ADDRESS_BITS (ADDRESS_BITS)
    ) u_engine (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fire        (fire),
        .i_op          (t_op'(r_op)),
        .i_address     (r_addr),
        .i_length      (r_len),
        .i_status_byte (r_status),
        .i_poll_limit  (r_poll_limit),
        .o_batch       (batch)
    );

    assign n_count = cnt_after + (fire ? (QAW + 1)'(batch.count) : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (fire) begin
                r_wr_ptr <= r_wr_ptr + QAW'(batch.count);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < MAX_RESULTS; k++) begin
            if (fire && (2'(k) < batch.count)) begin
                r_q[r_wr_ptr + QAW'(k)] <= batch.item[k];
            end
        end
    end

    assign head          = r_q[r_rd_ptr];
    assign m_axis_tvalid = (r_count != '0);
    assign m_axis_tuser  = head.kind;
    assign m_axis_tlast  = head.last;
    assign m_axis_tdata  = {3'b000, head.status_code, head.data_in, head.data_length,
                            head.address_out, head.has_address, head.command};

`ifndef SYNTHESIS
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (QAW + 1)'(QDEPTH))
        else $error("result queue overflow");

    a_busy_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && batch.busy && t_op'(r_op) != OPC_REPLY && t_op'(r_op) != OPC_TICK)
        |-> (batch.count == 2'd0))
        else $error("request taken while a write is in progress");

    a_idle_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && !batch.busy && t_op'(r_op) == OPC_TICK) |-> (batch.count == 2'd0))
        else $error("tick produced a result while idle");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> (r_count >= $past(cnt_after)))
        else $error("queue count lost entries on push");
`endif

endmodule

[hw/rtl/snc_engine.sv]
// Command sequencing engine: phase machine, page walk and poll counting.
`timescale 1ns / 1ps

module snc_engine
    import snc_pkg::*;
#(
    parameter int PAGE_BYTES   = 256,
    parameter int ADDRESS_BITS = 24
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_fire,
    input  t_op         i_op,
    input  logic [31:0] i_address,
    input  logic [24:0] i_length,
    input  logic [7:0]  i_status_byte,
    input  logic [15:0] i_poll_limit,
    output t_batch      o_batch
);

    localparam int PLW = $clog2(PAGE_BYTES + 1);
    localparam int CAW = ADDRESS_BITS + 1;
    localparam logic [33:0] TOP  = 34'd1 << ADDRESS_BITS;
    localparam logic [33:0] PAGE = 34'(PAGE_BYTES);

    t_phase          r_phase, n_phase;
    logic [15:0]     r_poll, n_poll;
    logic [CAW-1:0]  r_cur, n_cur;
    logic [24:0]     r_rem, n_rem;
    logic [PLW-1:0]  r_page, n_page;

    logic            busy;
    logic [33:0]     sp_addr;
    logic [24:0]     sp_rem;
    logic [PLW-1:0]  pg_len;
    logic            pg_bad;
    logic [33:0]     rd_end;
    logic            rd_bad;
    t_batch          b;

    assign busy = (r_phase != PH_IDLE);

    always_comb begin
        if (i_op == OPC_WRITE) begin
            sp_addr = 34'(i_address);
            sp_rem  = i_length;
        end else begin
            sp_addr = 34'(r_cur) + 34'(r_page);
            sp_rem  = r_rem - 25'(r_page);
        end
        pg_len = (sp_rem < 25'(PAGE_BYTES)) ? PLW'(sp_rem) : PLW'(PAGE_BYTES);
        pg_bad = (sp_addr >= TOP) || ((sp_addr + 34'(pg_len)) > TOP);
        rd_end = 34'(i_address) + 34'(i_length);
        rd_bad = (34'(i_address) >= TOP) || (34'(i_length) > PAGE) || (rd_end > TOP);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_poll  <= '0;
            r_cur   <= '0;
            r_rem   <= '0;
            r_page  <= '0;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_poll  <= n_poll;
            r_cur   <= n_cur;
            r_rem   <= n_rem;
            r_page  <= n_page;
        end
    end

    always_comb begin
        n_phase = r_phase;
        n_poll  = r_poll;
        n_cur   = r_cur;
        n_rem   = r_rem;
        n_page  = r_page;
        b       = '0;
        b.busy  = busy;
        unique case (i_op)
            OPC_READ: begin
                if (!busy) begin
                    if (rd_bad) begin
                        b.item[0] = mk_done(ST_RANGE);
                        b.count   = 2'd1;
                    end else begin
                        b.item[0] = mk_xfer(SPI_READ_DATA, 1'b1, i_address[23:0],
                                            i_length[8:0], 1'b1);
                        b.item[1] = mk_done(ST_OK);
                        b.count   = 2'd2;
                    end
                end
            end
            OPC_WRITE: begin
                if (!busy) begin
                    if (i_length == 25'd0) begin
                        b.item[0] = mk_done(ST_OK);
                        b.count   = 2'd1;
                    end else begin
                        n_cur  = CAW'(sp_addr);
                        n_rem  = sp_rem;
                        n_page = pg_len;
                        if (pg_bad) begin
                            b.item[0] = mk_done(ST_RANGE);
                            b.count   = 2'd1;
                        end else begin
                            b.item[0] = mk_xfer(SPI_WRITE_ENABLE, 1'b0, 24'd0, 9'd0, 1'b0);
                            b.item[1] = mk_xfer(SPI_READ_STATUS, 1'b0, 24'd0, 9'd1, 1'b1);
                            b.count   = 2'd2;
                            n_poll    = '0;
                            n_phase   = PH_WEL_REPLY;
                        end
                    end
                end
            end
            OPC_STATUS: begin
                if (!busy) begin
                    b.item[0] = mk_xfer(SPI_READ_STATUS, 1'b0, 24'd0, 9'd1, 1'b1);
                    b.item[1] = mk_done(ST_OK);
                    b.count   = 2'd2;
                end
            end
            OPC_ID: begin
                if (!busy) begin
                    b.item[0] = mk_xfer(SPI_READ_ID, 1'b0, 24'd0, 9'd3, 1'b1);
                    b.item[1] = mk_done(ST_OK);
                    b.count   = 2'd2;
                end
            end
            OPC_SLEEP: begin
                if (!busy) begin
                    b.item[0] = mk_xfer(SPI_POWER_DOWN, 1'b0, 24'd0, 9'd0, 1'b0);
                    b.item[1] = mk_done(ST_OK);
                    b.count   = 2'd2;
                end
            end
            OPC_WAKE: begin
                if (!busy) begin
                    b.item[0] = mk_xfer(SPI_POWER_UP, 1'b0, 24'd0, 9'd0, 1'b0);
                    b.item[1] = mk_done(ST_OK);
                    b.count   = 2'd2;
                end
            end
            OPC_REPLY: begin
                if (r_phase == PH_WEL_REPLY) begin
                    if (i_status_byte[1]) begin
                        b.item[0] = mk_xfer(SPI_PAGE_PROGRAM, 1'b1, 24'(r_cur), 9'(r_page),
                                            1'b0);
                        b.item[1] = mk_xfer(SPI_READ_STATUS, 1'b0, 24'd0, 9'd1, 1'b1);
                        b.count   = 2'd2;
                        n_poll    = '0;
                        n_phase   = PH_WIP_REPLY;
                    end else begin
                        b.item[0] = mk_wait();
                        b.count   = 2'd1;
                        n_poll    = r_poll + 16'(r_poll != 16'hFFFF);
                        n_phase   = PH_WEL_TICK;
                    end
                end else if (r_phase == PH_WIP_REPLY) begin
                    if (!i_status_byte[0]) begin
                        b.item[0] = mk_xfer(SPI_WRITE_DISABLE, 1'b0, 24'd0, 9'd0, 1'b0);
                        n_cur     = CAW'(sp_addr);
                        n_rem     = sp_rem;
                        if (sp_rem == 25'd0) begin
                            b.item[1] = mk_done(ST_OK);
                            b.count   = 2'd2;
                            n_phase   = PH_IDLE;
                        end else begin
                            n_page = pg_len;
                            if (pg_bad) begin
                                b.item[1] = mk_done(ST_RANGE);
                                b.count   = 2'd2;
                                n_phase   = PH_IDLE;
                            end else begin
                                b.item[1] = mk_xfer(SPI_WRITE_ENABLE, 1'b0, 24'd0, 9'd0,
                                                    1'b0);
                                b.item[2] = mk_xfer(SPI_READ_STATUS, 1'b0, 24'd0, 9'd1,
                                                    1'b1);
                                b.count   = 2'd3;
                                n_poll    = '0;
                                n_phase   = PH_WEL_REPLY;
                            end
                        end
                    end else begin
                        b.item[0] = mk_wait();
                        b.count   = 2'd1;
                        n_poll    = r_poll + 16'(r_poll != 16'hFFFF);
                        n_phase   = PH_WIP_TICK;
                    end
                end
            end
            OPC_TICK: begin
                if (r_phase == PH_WEL_TICK || r_phase == PH_WIP_TICK) begin
                    b.count = 2'd1;
                    if (r_poll >= i_poll_limit) begin
                        b.item[0] = mk_done((r_phase == PH_WEL_TICK) ? ST_WEL_TIMEOUT
                                                                     : ST_WIP_TIMEOUT);
                        n_phase   = PH_IDLE;
                    end else begin
                        b.item[0] = mk_xfer(SPI_READ_STATUS, 1'b0, 24'd0, 9'd1, 1'b1);
                        n_phase   = (r_phase == PH_WEL_TICK) ? PH_WEL_REPLY : PH_WIP_REPLY;
                    end
                end
            end
            default: begin
            end
        endcase
        for (int k = 0; k < MAX_RESULTS; k++) begin
            b.item[k].last = (2'(k + 1) == b.count);
        end
    end

    assign o_batch = b;

endmodule
